// ----- rtl/cfr_pkg.sv -----
`default_nettype none

package cfr_pkg;

   // expansion limits and fixed-point format
   localparam int MAX_TERMS = 50;
   localparam int FRAC_BITS = 32;

   // field widths
   localparam int IN_W   = 49;
   localparam int REM_W  = IN_W;
   localparam int TERM_W = IN_W - FRAC_BITS;
   localparam int NUM_W  = 32;
   localparam int THR_W  = 16;
   localparam int CNT_W  = 6;
   localparam int QUO_W  = NUM_W + THR_W;
   localparam int PROD_W = NUM_W + TERM_W;

   // reciprocal unit retires two quotient bits per cycle
   localparam int DIV_CYCLES = FRAC_BITS;
   localparam int DIV_CNT_W  = $clog2(DIV_CYCLES);

   // constants
   localparam logic [THR_W-1:0]  THRESH_RESET = THR_W'(1000);
   localparam logic [PROD_W-1:0] ONE_FIX      = PROD_W'(1) << FRAC_BITS;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TERM_MUL,
      ST_TERM_CHK,
      ST_DIV_WAIT,
      ST_FOLD_RD,
      ST_FOLD_MUL,
      ST_FOLD_ADD
   } cfr_state_type;

endpackage

`default_nettype wire

// ----- rtl/continued_fraction_rationalizer.sv -----
// Rational approximation of a signed Q16.32 value by continued fractions. A transaction
// is taken when start is high and busy is low; busy then stays high until the result,
// which appears on the rsp_ ports for exactly one cycle with rsp_valid high and must be
// captured then, since the receiver cannot stall. Each term that needs a reciprocal takes
// a step to write the term and multiply the fraction by the threshold, a step to test,
// and a wait on the reciprocal divider, which retires two quotient bits per cycle and
// raises done in the cycle after its last step; the last term takes only the first two
// steps. The fold back then takes, per term, a term memory read, a shared 32x17
// multiply and an add; busy drops in the same cycle as the result appears.
// The numerator and denominator wrap to 32 bits; rsp_overflow flags any fold value
// above 2147483647.
`default_nettype none

module continued_fraction_rationalizer import cfr_pkg::*; (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   output logic                         busy,
   input  wire logic signed [IN_W-1:0]  req_value,
   input  wire logic                    csr_wr_en,
   input  wire logic [THR_W-1:0]        csr_wr_data,
   output logic                         rsp_valid,
   output logic signed [NUM_W-1:0]      rsp_numerator,
   output logic signed [NUM_W-1:0]      rsp_denominator,
   output logic [CNT_W-1:0]             rsp_terms_used,
   output logic                         rsp_overflow
);

   cfr_state_type state_ff, state_in;

   logic [THR_W-1:0]  thresh_ff;
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic              neg_ff, neg_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  k_ff, k_in;
   logic [NUM_W-1:0]  upper_ff, upper_in;
   logic [NUM_W-1:0]  lower_ff, lower_in;
   logic              ovf_ff, ovf_in;
   logic [PROD_W-1:0] prod_ff;
   logic [TERM_W-1:0] rd_data_ff;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [NUM_W-1:0]  rsp_num_ff, rsp_num_in;
   logic [NUM_W-1:0]  rsp_den_ff, rsp_den_in;
   logic [CNT_W-1:0]  rsp_terms_ff, rsp_terms_in;
   logic              rsp_ovf_ff, rsp_ovf_in;

   logic [TERM_W-1:0] term_mem [MAX_TERMS];

   logic [NUM_W-1:0]  mul_a;
   logic [TERM_W-1:0] mul_b;
   logic [IN_W-1:0]   raw;
   logic [IN_W-1:0]   mag;
   logic [PROD_W:0]   exact;
   logic [NUM_W-1:0]  sum;
   logic              ovf_now;
   logic              div_start;
   logic              div_done;
   logic [QUO_W-1:0]  div_quotient;

   // shared reciprocal unit
   cfr_recip_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .divisor  (rem_ff[FRAC_BITS-1:0]),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // shared multiplier: fraction by threshold, or term by running numerator
   always_comb begin
      if (state_ff == ST_TERM_MUL) begin
         mul_a = rem_ff[FRAC_BITS-1:0];
         mul_b = TERM_W'(thresh_ff);
      end else begin
         mul_a = upper_ff;
         mul_b = rd_data_ff;
      end
   end

   // magnitude of the input and fold arithmetic
   always_comb begin
      raw     = unsigned'(req_value);
      mag     = raw[IN_W-1] ? (~raw + IN_W'(1)) : raw;
      exact   = {1'b0, prod_ff} + (PROD_W + 1)'(lower_ff);
      sum     = exact[NUM_W-1:0];
      ovf_now = ovf_ff | (exact[PROD_W:NUM_W-1] != '0);
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      rem_in       = rem_ff;
      neg_in       = neg_ff;
      count_in     = count_ff;
      k_in         = k_ff;
      upper_in     = upper_ff;
      lower_in     = lower_ff;
      ovf_in       = ovf_ff;
      div_start    = 1'b0;
      rsp_valid_in = 1'b0;
      rsp_num_in   = rsp_num_ff;
      rsp_den_in   = rsp_den_ff;
      rsp_terms_in = rsp_terms_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               neg_in   = raw[IN_W-1];
               rem_in   = REM_W'(mag);
               count_in = '0;
               state_in = ST_TERM_MUL;
            end
         end
         ST_TERM_MUL: begin
            count_in = count_ff + 1'b1;
            state_in = ST_TERM_CHK;
         end
         ST_TERM_CHK: begin
            // stop when the reciprocal would reach the threshold or the store is full
            if (prod_ff <= ONE_FIX || count_ff >= CNT_W'(MAX_TERMS)) begin
               k_in     = count_ff;
               upper_in = NUM_W'(1);
               lower_in = '0;
               ovf_in   = 1'b0;
               state_in = ST_FOLD_RD;
            end else begin
               div_start = 1'b1;
               state_in  = ST_DIV_WAIT;
            end
         end
         ST_DIV_WAIT: begin
            if (div_done) begin
               rem_in   = REM_W'(div_quotient);
               state_in = ST_TERM_MUL;
            end
         end
         ST_FOLD_RD: begin
            state_in = ST_FOLD_MUL;
         end
         ST_FOLD_MUL: begin
            state_in = ST_FOLD_ADD;
         end
         ST_FOLD_ADD: begin
            upper_in = sum;
            lower_in = upper_ff;
            ovf_in   = ovf_now;
            k_in     = k_ff - 1'b1;
            if (k_ff == CNT_W'(1)) begin
               rsp_valid_in = 1'b1;
               rsp_num_in   = neg_ff ? (NUM_W'(0) - sum) : sum;
               rsp_den_in   = upper_ff;
               rsp_terms_in = count_ff;
               rsp_ovf_in   = ovf_now;
               state_in     = ST_IDLE;
            end else begin
               state_in = ST_FOLD_RD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state and control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         thresh_ff    <= THRESH_RESET;
         rem_ff       <= '0;
         neg_ff       <= 1'b0;
         count_ff     <= '0;
         k_ff         <= '0;
         upper_ff     <= NUM_W'(1);
         lower_ff     <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rem_ff       <= rem_in;
         neg_ff       <= neg_in;
         count_ff     <= count_in;
         k_ff         <= k_in;
         upper_ff     <= upper_in;
         lower_ff     <= lower_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            thresh_ff <= csr_wr_data;
         end
      end
   end

   // datapath and result registers
   always_ff @(posedge clock) begin
      prod_ff      <= mul_a * mul_b;
      rsp_num_ff   <= rsp_num_in;
      rsp_den_ff   <= rsp_den_in;
      rsp_terms_ff <= rsp_terms_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   // term memory: written during expansion, read last to first during the fold
   always_ff @(posedge clock) begin
      if (state_ff == ST_TERM_MUL) begin
         term_mem[count_ff] <= rem_ff[REM_W-1:FRAC_BITS];
      end
      if (state_ff == ST_FOLD_RD) begin
         rd_data_ff <= term_mem[k_ff - 1'b1];
      end
   end

   assign busy            = (state_ff != ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_numerator   = signed'(rsp_num_ff);
   assign rsp_denominator = signed'(rsp_den_ff);
   assign rsp_terms_used  = rsp_terms_ff;
   assign rsp_overflow    = rsp_ovf_ff;

endmodule

`default_nettype wire

// ----- rtl/cfr_recip_div.sv -----
`default_nettype none

module cfr_recip_div import cfr_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [NUM_W-1:0] divisor,
   output logic                  done,
   output logic [QUO_W-1:0]      quotient
);

   logic                 run_ff, run_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [NUM_W-1:0]     rem_ff, rem_in;
   logic [QUO_W-1:0]     quo_ff, quo_in;
   logic [NUM_W-1:0]     dvs_ff, dvs_in;

   logic [NUM_W:0]   t1, t2;
   logic             b1, b2;
   logic [NUM_W-1:0] r1, r2;

   // two restoring steps of 2^(2*frac_bits) / divisor per cycle
   always_comb begin
      t1 = {rem_ff, 1'b0};
      b1 = (t1 >= {1'b0, dvs_ff});
      r1 = b1 ? NUM_W'(t1 - {1'b0, dvs_ff}) : t1[NUM_W-1:0];
      t2 = {r1, 1'b0};
      b2 = (t2 >= {1'b0, dvs_ff});
      r2 = b2 ? NUM_W'(t2 - {1'b0, dvs_ff}) : t2[NUM_W-1:0];
   end

   // iteration control
   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         run_in = 1'b1;
         cnt_in = '0;
         rem_in = NUM_W'(1);
         quo_in = '0;
         dvs_in = divisor;
      end else if (run_ff) begin
         rem_in = r2;
         quo_in = {quo_ff[QUO_W-3:0], b1, b2};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(DIV_CYCLES - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

// ----- test/continued_fraction_rationalizer_tb.sv -----
module continued_fraction_rationalizer_tb;
   import cfr_pkg::*;

   localparam int IDLE_LIMIT      = 8000;
   localparam int DRAIN_CYCLES    = 100;
   localparam int RANDOM_PHASES   = 6;
   localparam int ITEMS_PER_PHASE = 50;

   // one expected approximation
   typedef struct {
      logic [NUM_W-1:0] numerator;
      logic [NUM_W-1:0] denominator;
      logic [CNT_W-1:0] terms_used;
      logic             overflow;
   } fraction_type;

   // predicts approximations and holds them until the block reports them
   class fraction_ledger_type;
      logic [THR_W-1:0] stop_threshold;
      fraction_type     expected_fractions[$];
      int               mismatches;

      function new();
         stop_threshold = THRESH_RESET;
         mismatches     = 0;
      endfunction

      // continued-fraction expansion of the magnitude, then fold back
      function fraction_type rationalize(logic [IN_W-1:0] raw);
         logic             neg;
         logic [IN_W-1:0]  mag;
         logic [63:0]      rem;
         logic [31:0]      frac;
         logic [127:0]     quot;
         logic [63:0]      term_list [0:MAX_TERMS-1];
         logic [63:0]      exact;
         logic [NUM_W-1:0] upper;
         logic [NUM_W-1:0] lower;
         logic [NUM_W-1:0] sum;
         int               count;
         int               k;
         bit               go;
         bit               ovf;
         fraction_type     res;
         neg   = raw[IN_W-1];
         mag   = neg ? (~raw + 1'b1) : raw;
         rem   = 64'(mag);
         count = 0;
         do begin
            frac = rem[31:0];
            term_list[count] = rem >> FRAC_BITS;
            count++;
            if (frac == 0 || 64'(frac) * 64'(stop_threshold) <= (64'd1 << FRAC_BITS)) begin
               go = 0;
            end else begin
               quot = (128'd1 << (2 * FRAC_BITS)) / 128'(frac);
               rem  = quot[63:0];
               go   = 1;
            end
         end while (go && count < MAX_TERMS);

         // fold from the last term to the first, wrapping at 32 bits
         upper = 1;
         lower = 0;
         ovf   = 0;
         for (k = count; k > 0; k--) begin
            exact = 64'(lower) + term_list[k-1] * 64'(upper);
            if (exact > 64'h7FFF_FFFF)
               ovf = 1;
            sum   = lower + term_list[k-1][31:0] * upper;
            lower = upper;
            upper = sum;
         end
         res.numerator   = neg ? (32'd0 - upper) : upper;
         res.denominator = lower;
         res.terms_used  = CNT_W'(count);
         res.overflow    = ovf;
         return res;
      endfunction

      function void note_value(logic [IN_W-1:0] raw);
         expected_fractions = {expected_fractions, rationalize(raw)};
      endfunction

      function void check_fraction(logic [NUM_W-1:0] num, logic [NUM_W-1:0] den,
                                   logic [CNT_W-1:0] terms, logic ovf);
         fraction_type want;
         if (expected_fractions.size() == 0) begin
            $error("result with no transaction outstanding: numerator %0d", $signed(num));
            mismatches++;
            return;
         end
         want = expected_fractions.pop_front();
         if (num !== want.numerator) begin
            $error("numerator: expected %0d, got %0d", $signed(want.numerator), $signed(num));
            mismatches++;
         end
         if (den !== want.denominator) begin
            $error("denominator: expected %0d, got %0d", $signed(want.denominator),
                   $signed(den));
            mismatches++;
         end
         if (terms !== want.terms_used) begin
            $error("terms_used: expected %0d, got %0d", want.terms_used, terms);
            mismatches++;
         end
         if (ovf !== want.overflow) begin
            $error("overflow: expected %0b, got %0b", want.overflow, ovf);
            mismatches++;
         end
      endfunction

      function int outstanding();
         return expected_fractions.size();
      endfunction
   endclass

   logic                   clock;
   logic                   reset;
   logic                   start;
   logic                   busy;
   logic [IN_W-1:0]        req_value;
   logic                   csr_wr_en;
   logic [THR_W-1:0]       csr_wr_data;
   logic                   rsp_valid;
   logic [NUM_W-1:0]       rsp_numerator;
   logic [NUM_W-1:0]       rsp_denominator;
   logic [CNT_W-1:0]       rsp_terms_used;
   logic                   rsp_overflow;

   fraction_ledger_type ledger = new();
   int                  idle_cycles;

   // corner values at the reset threshold
   logic [IN_W-1:0] corner_values [15] = '{
      49'h0_0000_0000_0000,   // zero
      49'h0_0000_0000_0001,   // smallest positive step
      49'h1_FFFF_FFFF_FFFF,   // smallest negative step
      49'h0_FFFF_FFFF_FFFF,   // most positive
      49'h1_0000_0000_0000,   // most negative, integer part past 16 bits
      49'h0_0001_0000_0000,   // one
      49'h1_FFFF_0000_0000,   // minus one
      49'h0_0000_8000_0000,   // one half
      49'h1_FFFF_8000_0000,   // minus one half
      49'h0_0000_5555_5555,   // one third
      49'h0_0003_243F_6A88,   // pi
      49'h1_FFFC_DBC0_9578,   // minus pi
      49'h0_0001_9E37_79B9,   // golden ratio, all ones terms
      49'h0_0001_6A09_E667,   // square root of two
      49'h0_FFFF_0000_0000    // large integer, no fraction
   };

   continued_fraction_rationalizer i_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_value       (req_value),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .rsp_valid       (rsp_valid),
      .rsp_numerator   (rsp_numerator),
      .rsp_denominator (rsp_denominator),
      .rsp_terms_used  (rsp_terms_used),
      .rsp_overflow    (rsp_overflow)
   );

   always #5 clock = ~clock;

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1)
         ledger.check_fraction(rsp_numerator, rsp_denominator, rsp_terms_used, rsp_overflow);
   end

   // watchdog on cycles with no transaction on either side
   always @(posedge clock) begin
      if (reset || (start === 1'b1 && busy === 1'b0) || rsp_valid === 1'b1) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // random fixed-point value with a mix of shapes
   function automatic logic [IN_W-1:0] pick_fixed_value();
      int              kind;
      int              p;
      int              q;
      logic [63:0]     wide;
      logic [63:0]     base;
      logic [IN_W-1:0] mag;
      bit              neg;
      kind = $urandom_range(0, 9);
      neg  = $urandom_range(0, 1);
      mag  = '0;
      case (kind)
         4: begin
            mag = (IN_W'($urandom_range(0, 3)) << FRAC_BITS) | IN_W'($urandom);
         end
         5: begin
            p    = $urandom_range(1, 200);
            q    = $urandom_range(1, 200);
            wide = (64'(p) << FRAC_BITS) / 64'(q);
            mag  = wide[IN_W-1:0];
         end
         6: begin
            mag = IN_W'($urandom_range(0, 65535)) << FRAC_BITS;
         end
         7: begin
            mag = IN_W'($urandom_range(0, 1 << 20));
         end
         8: begin
            base = 64'($urandom_range(1, 65535)) << FRAC_BITS;
            wide = $urandom_range(0, 1) ? base + 64'($urandom_range(1, 255))
                                        : base - 64'($urandom_range(1, 255));
            mag  = wide[IN_W-1:0];
         end
         9: begin
            case ($urandom_range(0, 3))
               0: mag = 49'h1_0000_0000_0000;
               1: mag = 49'h0_FFFF_FFFF_FFFF;
               2: mag = '0;
               default: mag = 49'h0_0000_0000_0001;
            endcase
         end
         default: begin
            wide = {$urandom, $urandom};
            return wide[IN_W-1:0];
         end
      endcase
      return neg ? (~mag + 1'b1) : mag;
   endfunction

   // present one value and hold it until taken; returns at the next falling edge
   task automatic send_value(logic [IN_W-1:0] value, bit no_gaps);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         start = 0;
         repeat (gap) @(negedge clock);
      end
      req_value = value;
      start     = 1;
      do
         @(posedge clock);
      while (busy !== 1'b0);
      ledger.note_value(value);
      @(negedge clock);
   endtask

   // drop start and wait until the block is idle with nothing outstanding
   task automatic wait_idle();
      start = 0;
      while (ledger.outstanding() != 0 || busy !== 1'b0)
         @(negedge clock);
   endtask

   task automatic write_threshold(logic [THR_W-1:0] value);
      wait_idle();
      csr_wr_en   = 1;
      csr_wr_data = value;
      @(posedge clock);
      ledger.stop_threshold = value;
      @(negedge clock);
      csr_wr_en = 0;
   endtask

   initial begin
      bit               no_gaps;
      logic [THR_W-1:0] thr;
      clock       = 0;
      reset       = 1;
      start       = 0;
      req_value   = '0;
      csr_wr_en   = 0;
      csr_wr_data = '0;
      idle_cycles = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed values at the reset threshold
      foreach (corner_values[i])
         send_value(corner_values[i], 1'b0);

      // threshold zero takes exactly one term
      write_threshold(16'd0);
      send_value(49'h0_0003_243F_6A88, 1'b0);
      send_value(49'h1_FFFF_FFFF_FFFF, 1'b0);

      // widest threshold, longest expansions
      write_threshold(16'hFFFF);
      send_value(49'h0_0001_9E37_79B9, 1'b1);
      send_value(49'h0_0001_6A09_E667, 1'b1);
      send_value(49'h0_0000_5555_5555, 1'b1);

      write_threshold(16'd1);
      send_value(49'h0_0002_B7E1_5162, 1'b0);
      send_value(49'h0_FFFF_FFFF_FFFF, 1'b0);

      // random phases, each under its own threshold
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0: thr = 16'hFFFF;
            1: thr = 16'd1;
            2: thr = THR_W'($urandom_range(2, 16));
            default: thr = THR_W'($urandom_range(1, 65535));
         endcase
         write_threshold(thr);
         no_gaps = ($urandom_range(0, 3) == 0);
         repeat (ITEMS_PER_PHASE)
            send_value(pick_fixed_value(), no_gaps);
      end

      // drain and watch for stray results
      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (ledger.mismatches == 0 && ledger.outstanding() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
